// ===== design/orcc_pkg.sv =====
// Shared types, constants and sine table math for the oriented rectangle
// versus circle contact pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package orcc_pkg;

    localparam int COORD_WIDTH_DEF      = 16;
    localparam int SINE_TABLE_DEPTH_DEF = 256;

    // half extents and radius
    localparam int EXT_WIDTH   = 12;
    // Q15 sine, range -32768..32768
    localparam int SIN_WIDTH   = 17;
    localparam int FRAC_SHIFT  = 15;
    localparam int ROUND_HALF  = 16384;
    localparam int ANGLE_WIDTH = 16;
    localparam logic [ANGLE_WIDTH-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [ANGLE_WIDTH-1:0] HALF_TURN    = 16'h8000;

    typedef enum logic [1:0] {
        REG_HALF_WIDTH  = 2'd0,
        REG_HALF_HEIGHT = 2'd1,
        REG_CENTER_X    = 2'd2,
        REG_CENTER_Y    = 2'd3
    } t_reg_index;

    typedef enum logic [2:0] {
        VERDICT_COARSE = 3'd0,
        VERDICT_X_MISS = 3'd1,
        VERDICT_Y_MISS = 3'd2,
        VERDICT_CORNER = 3'd3,
        VERDICT_HIT    = 3'd4
    } t_verdict;

    // control that rides along each stage
    typedef struct packed {
        logic     valid;
        logic     decided;
        t_verdict verdict;
    } t_ctl;

    // quarter-wave polynomial, Q15, each product truncated
    function automatic longint quarter_wave(input longint x);
        longint x2;
        longint t;
        x2 = (x * x) >> 15;
        t  = (2320 * x2) >> 15;
        t  = 21024 - t;
        t  = (t * x2) >> 15;
        t  = 51472 - t;
        return (t * x) >> 15;
    endfunction

    // sine of a phase in 1/65536 turn; elaboration use only
    function automatic logic signed [SIN_WIDTH-1:0] sine_of_phase(input longint phase);
        longint quad;
        longint x;
        longint y;
        quad = (phase >> 14) & 3;
        x    = (phase & 16383) << 1;
        if (quad[0]) begin
            x = 32768 - x;
        end
        y = quarter_wave(x);
        if (quad >= 2) begin
            y = -y;
        end
        return SIN_WIDTH'(y);
    endfunction

endpackage

`default_nettype wire

// ===== design/oriented_rect_circle_collide_core.sv =====
// Oriented rectangle versus circle contact test, top level: configuration
// registers and the chain of pipeline cells. Depends on orcc_pkg,
// orcc_front, orcc_rotate, orcc_box.
`timescale 1ns / 1ps
`default_nettype none

// One item enters on every clock: busy stays low, so an item is taken at
// any edge where start is high. Each item gives exactly one result,
// shown for a single cycle with o_strobe high; there is no way to hold
// results off, so the receiver must take them as they come. Items stay
// in order. Each item passes through the cell chain in turn:
// two front cells (offset vector and Manhattan reject, table index), the
// registered sine/cosine table read, the four rotation products, the
// rounding sums, and four box cells (centre offset, extent tests, corner
// squares, verdict). Configuration writes take effect on the next clock
// and are to be made only while no item is in flight.

module oriented_rect_circle_collide_core #(
    parameter int COORD_WIDTH      = orcc_pkg::COORD_WIDTH_DEF,
    parameter int SINE_TABLE_DEPTH = orcc_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // item in
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic signed [COORD_WIDTH-1:0]          i_rect_x,
    input  wire logic signed [COORD_WIDTH-1:0]          i_rect_y,
    input  wire logic [orcc_pkg::ANGLE_WIDTH-1:0]       i_angle,
    input  wire logic signed [COORD_WIDTH-1:0]          i_circle_x,
    input  wire logic signed [COORD_WIDTH-1:0]          i_circle_y,
    input  wire logic [orcc_pkg::EXT_WIDTH-1:0]         i_circle_radius,
    // result out
    output logic                                        o_strobe,
    output logic                                        o_hit,
    output logic [2:0]                                  o_verdict,
    // configuration write port
    input  wire logic                                   i_cfg_we,
    input  wire logic [1:0]                             i_cfg_index,
    input  wire logic [COORD_WIDTH-1:0]                 i_cfg_data
);
    import orcc_pkg::*;

    localparam int IDX_WIDTH = $clog2(SINE_TABLE_DEPTH);
    localparam int ROT_WIDTH = COORD_WIDTH + 4;

    // ---- configuration registers
    logic [EXT_WIDTH-1:0]           r_half_width, r_half_height;
    logic signed [COORD_WIDTH-1:0]  r_center_x, r_center_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width  <= '0;
            r_half_height <= '0;
            r_center_x    <= '0;
            r_center_y    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_HALF_WIDTH:  r_half_width  <= i_cfg_data[EXT_WIDTH-1:0];
                REG_HALF_HEIGHT: r_half_height <= i_cfg_data[EXT_WIDTH-1:0];
                REG_CENTER_X:    r_center_x    <= i_cfg_data;
                REG_CENTER_Y:    r_center_y    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // never stalls
    assign busy = 1'b0;

    // ---- front cells: offset, coarse reject, table indexes
    t_ctl                           w_front_ctl;
    logic signed [COORD_WIDTH:0]    w_dx, w_dy;
    logic [EXT_WIDTH-1:0]           w_front_radius;
    logic [IDX_WIDTH-1:0]           w_idx_sin, w_idx_cos;

    orcc_front #(
        .COORD_WIDTH      (COORD_WIDTH),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (start && !busy),
        .i_rect_x        (i_rect_x),
        .i_rect_y        (i_rect_y),
        .i_angle         (i_angle),
        .i_circle_x      (i_circle_x),
        .i_circle_y      (i_circle_y),
        .i_circle_radius (i_circle_radius),
        .i_half_width    (r_half_width),
        .i_half_height   (r_half_height),
        .i_center_x      (r_center_x),
        .i_center_y      (r_center_y),
        .o_ctl           (w_front_ctl),
        .o_dx            (w_dx),
        .o_dy            (w_dy),
        .o_radius        (w_front_radius),
        .o_idx_sin       (w_idx_sin),
        .o_idx_cos       (w_idx_cos)
    );

    // ---- rotation cells: into the rectangle frame
    t_ctl                           w_rot_ctl;
    logic signed [ROT_WIDTH-1:0]    w_px, w_py;
    logic [EXT_WIDTH-1:0]           w_rot_radius;

    orcc_rotate #(
        .COORD_WIDTH      (COORD_WIDTH),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rotate (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_front_ctl),
        .i_dx      (w_dx),
        .i_dy      (w_dy),
        .i_radius  (w_front_radius),
        .i_idx_sin (w_idx_sin),
        .i_idx_cos (w_idx_cos),
        .o_ctl     (w_rot_ctl),
        .o_px      (w_px),
        .o_py      (w_py),
        .o_radius  (w_rot_radius)
    );

    // ---- box cells: extents and corner
    t_ctl w_box_ctl;

    orcc_box #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_box (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_rot_ctl),
        .i_px          (w_px),
        .i_py          (w_py),
        .i_radius      (w_rot_radius),
        .i_half_width  (r_half_width),
        .i_half_height (r_half_height),
        .i_center_x    (r_center_x),
        .i_center_y    (r_center_y),
        .o_ctl         (w_box_ctl)
    );

    // result straight from the last cell's register
    assign o_strobe  = w_box_ctl.valid;
    assign o_verdict = w_box_ctl.verdict;
    assign o_hit     = (w_box_ctl.verdict == VERDICT_HIT);

endmodule

`default_nettype wire

// ===== design/orcc_sine_rom.sv =====
// Constant sine table with two registered read ports (sine and cosine).
// Depends on orcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module orcc_sine_rom #(
    parameter int  SINE_TABLE_DEPTH = orcc_pkg::SINE_TABLE_DEPTH_DEF,
    localparam int IDX_WIDTH        = $clog2(SINE_TABLE_DEPTH)
) (
    input  wire logic                                  i_clk,
    input  wire logic [IDX_WIDTH-1:0]                  i_idx_sin,
    input  wire logic [IDX_WIDTH-1:0]                  i_idx_cos,
    output logic signed [orcc_pkg::SIN_WIDTH-1:0]      o_sin,
    output logic signed [orcc_pkg::SIN_WIDTH-1:0]      o_cos
);
    import orcc_pkg::*;

    logic signed [SIN_WIDTH-1:0] w_rom [SINE_TABLE_DEPTH];

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
        localparam longint PHASE = (longint'(g) * 65536) / SINE_TABLE_DEPTH;
        assign w_rom[g] = sine_of_phase(PHASE);
    end

    always_ff @(posedge i_clk) begin
        o_sin <= w_rom[i_idx_sin];
        o_cos <= w_rom[i_idx_cos];
    end

endmodule

`default_nettype wire

// ===== design/orcc_front.sv =====
// Front cells: offset vector, coarse Manhattan reject and sine table indexes.
// Depends on orcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module orcc_front #(
    parameter int  COORD_WIDTH      = orcc_pkg::COORD_WIDTH_DEF,
    parameter int  SINE_TABLE_DEPTH = orcc_pkg::SINE_TABLE_DEPTH_DEF,
    localparam int IDX_WIDTH        = $clog2(SINE_TABLE_DEPTH)
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    input  wire logic signed [COORD_WIDTH-1:0]          i_rect_x,
    input  wire logic signed [COORD_WIDTH-1:0]          i_rect_y,
    input  wire logic [orcc_pkg::ANGLE_WIDTH-1:0]       i_angle,
    input  wire logic signed [COORD_WIDTH-1:0]          i_circle_x,
    input  wire logic signed [COORD_WIDTH-1:0]          i_circle_y,
    input  wire logic [orcc_pkg::EXT_WIDTH-1:0]         i_circle_radius,
    input  wire logic [orcc_pkg::EXT_WIDTH-1:0]         i_half_width,
    input  wire logic [orcc_pkg::EXT_WIDTH-1:0]         i_half_height,
    input  wire logic signed [COORD_WIDTH-1:0]          i_center_x,
    input  wire logic signed [COORD_WIDTH-1:0]          i_center_y,
    output orcc_pkg::t_ctl                              o_ctl,
    output logic signed [COORD_WIDTH:0]                 o_dx,
    output logic signed [COORD_WIDTH:0]                 o_dy,
    output logic [orcc_pkg::EXT_WIDTH-1:0]              o_radius,
    output logic [IDX_WIDTH-1:0]                        o_idx_sin,
    output logic [IDX_WIDTH-1:0]                        o_idx_cos
);
    import orcc_pkg::*;

    localparam int DW     = COORD_WIDTH + 1;
    localparam int LIMW   = COORD_WIDTH + 4;
    localparam int PRODW  = ANGLE_WIDTH + IDX_WIDTH + 1;

    // ---- cell A: differences, phases, reject bound
    logic                    r_a_valid;
    logic signed [DW-1:0]    r_a_dx, r_a_dy;
    logic [ANGLE_WIDTH-1:0]  r_a_sin_phase, r_a_cos_phase;
    logic [EXT_WIDTH-1:0]    r_a_radius;
    logic [LIMW-1:0]         r_a_limit;

    logic [COORD_WIDTH-1:0]  w_abs_cx, w_abs_cy;
    logic [EXT_WIDTH+1:0]    w_ext_sum;
    logic [LIMW-1:0]         n_a_limit;

    always_comb begin
        w_abs_cx  = i_center_x[COORD_WIDTH-1] ? COORD_WIDTH'(-i_center_x)
                                              : COORD_WIDTH'(i_center_x);
        w_abs_cy  = i_center_y[COORD_WIDTH-1] ? COORD_WIDTH'(-i_center_y)
                                              : COORD_WIDTH'(i_center_y);
        w_ext_sum = (EXT_WIDTH+2)'(i_half_width) + (EXT_WIDTH+2)'(i_half_height)
                  + (EXT_WIDTH+2)'(i_circle_radius);
        n_a_limit = (LIMW'(w_ext_sum) << 1) + LIMW'(w_abs_cx) + LIMW'(w_abs_cy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a_dx        <= DW'(i_circle_x) - DW'(i_rect_x);
        r_a_dy        <= DW'(i_circle_y) - DW'(i_rect_y);
        r_a_sin_phase <= i_angle + QUARTER_TURN;
        r_a_cos_phase <= i_angle + HALF_TURN;
        r_a_radius    <= i_circle_radius;
        r_a_limit     <= n_a_limit;
    end

    // ---- cell B: Manhattan compare, table index scaling
    logic [DW-1:0]    w_abs_dx, w_abs_dy;
    logic [LIMW-1:0]  w_manhattan;
    logic [PRODW-1:0] w_prod_sin, w_prod_cos;
    t_ctl             n_b_ctl;

    always_comb begin
        w_abs_dx    = r_a_dx[DW-1] ? DW'(-r_a_dx) : DW'(r_a_dx);
        w_abs_dy    = r_a_dy[DW-1] ? DW'(-r_a_dy) : DW'(r_a_dy);
        w_manhattan = LIMW'(w_abs_dx) + LIMW'(w_abs_dy);
        w_prod_sin  = PRODW'(r_a_sin_phase) * PRODW'(SINE_TABLE_DEPTH);
        w_prod_cos  = PRODW'(r_a_cos_phase) * PRODW'(SINE_TABLE_DEPTH);
        n_b_ctl.valid   = r_a_valid;
        n_b_ctl.decided = (w_manhattan > r_a_limit);
        n_b_ctl.verdict = n_b_ctl.decided ? VERDICT_COARSE : VERDICT_HIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= n_b_ctl;
        end
        o_dx      <= r_a_dx;
        o_dy      <= r_a_dy;
        o_radius  <= r_a_radius;
        o_idx_sin <= w_prod_sin[ANGLE_WIDTH +: IDX_WIDTH];
        o_idx_cos <= w_prod_cos[ANGLE_WIDTH +: IDX_WIDTH];
    end

endmodule

`default_nettype wire

// ===== design/orcc_rotate.sv =====
// Rotation cells: table read, four products, sums with round half up.
// Depends on orcc_pkg and orcc_sine_rom.
`timescale 1ns / 1ps
`default_nettype none

module orcc_rotate #(
    parameter int  COORD_WIDTH      = orcc_pkg::COORD_WIDTH_DEF,
    parameter int  SINE_TABLE_DEPTH = orcc_pkg::SINE_TABLE_DEPTH_DEF,
    localparam int IDX_WIDTH        = $clog2(SINE_TABLE_DEPTH),
    localparam int ROT_WIDTH        = COORD_WIDTH + 4
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire orcc_pkg::t_ctl                         i_ctl,
    input  wire logic signed [COORD_WIDTH:0]            i_dx,
    input  wire logic signed [COORD_WIDTH:0]            i_dy,
    input  wire logic [orcc_pkg::EXT_WIDTH-1:0]         i_radius,
    input  wire logic [IDX_WIDTH-1:0]                   i_idx_sin,
    input  wire logic [IDX_WIDTH-1:0]                   i_idx_cos,
    output orcc_pkg::t_ctl                              o_ctl,
    output logic signed [ROT_WIDTH-1:0]                 o_px,
    output logic signed [ROT_WIDTH-1:0]                 o_py,
    output logic [orcc_pkg::EXT_WIDTH-1:0]              o_radius
);
    import orcc_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = DW + SIN_WIDTH;
    localparam int SW = PW + 1;

    // ---- cell C: table read (registered inside the ROM)
    logic signed [SIN_WIDTH-1:0] w_sin, w_cos;
    t_ctl                        r_c_ctl;
    logic signed [DW-1:0]        r_c_dx, r_c_dy;
    logic [EXT_WIDTH-1:0]        r_c_radius;

    orcc_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk     (i_clk),
        .i_idx_sin (i_idx_sin),
        .i_idx_cos (i_idx_cos),
        .o_sin     (w_sin),
        .o_cos     (w_cos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl <= '0;
        end else begin
            r_c_ctl <= i_ctl;
        end
        r_c_dx     <= i_dx;
        r_c_dy     <= i_dy;
        r_c_radius <= i_radius;
    end

    // ---- cell D: products
    t_ctl                 r_d_ctl;
    logic signed [PW-1:0] r_d_xc, r_d_ys, r_d_xs, r_d_yc;
    logic [EXT_WIDTH-1:0] r_d_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctl <= '0;
        end else begin
            r_d_ctl <= r_c_ctl;
        end
        r_d_xc     <= PW'(r_c_dx) * PW'(w_cos);
        r_d_ys     <= PW'(r_c_dy) * PW'(w_sin);
        r_d_xs     <= PW'(r_c_dx) * PW'(w_sin);
        r_d_yc     <= PW'(r_c_dy) * PW'(w_cos);
        r_d_radius <= r_c_radius;
    end

    // ---- cell E: sum, add half, floor shift
    logic signed [SW-1:0] w_sx, w_sy;

    always_comb begin
        w_sx = SW'(r_d_xc) - SW'(r_d_ys) + SW'(ROUND_HALF);
        w_sy = SW'(r_d_xs) + SW'(r_d_yc) + SW'(ROUND_HALF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= r_d_ctl;
        end
        o_px     <= w_sx[SW-1:FRAC_SHIFT];
        o_py     <= w_sy[SW-1:FRAC_SHIFT];
        o_radius <= r_d_radius;
    end

endmodule

`default_nettype wire

// ===== design/orcc_box.sv =====
// Box cells: centre offset, extent tests, corner distance, final verdict.
// Depends on orcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module orcc_box #(
    parameter int  COORD_WIDTH = orcc_pkg::COORD_WIDTH_DEF,
    localparam int ROT_WIDTH   = COORD_WIDTH + 4
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire orcc_pkg::t_ctl                         i_ctl,
    input  wire logic signed [ROT_WIDTH-1:0]            i_px,
    input  wire logic signed [ROT_WIDTH-1:0]            i_py,
    input  wire logic [orcc_pkg::EXT_WIDTH-1:0]         i_radius,
    input  wire logic [orcc_pkg::EXT_WIDTH-1:0]         i_half_width,
    input  wire logic [orcc_pkg::EXT_WIDTH-1:0]         i_half_height,
    input  wire logic signed [COORD_WIDTH-1:0]          i_center_x,
    input  wire logic signed [COORD_WIDTH-1:0]          i_center_y,
    output orcc_pkg::t_ctl                              o_ctl
);
    import orcc_pkg::*;

    localparam int EW = ROT_WIDTH + 1;   // offset from centre
    localparam int NW = EW + 1;          // distance past the edge
    localparam int QW = 2 * EXT_WIDTH;   // squares

    // ---- cell F: subtract centre offset
    t_ctl                 r_f_ctl;
    logic signed [EW-1:0] r_f_ex, r_f_ey;
    logic [EXT_WIDTH-1:0] r_f_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_ctl <= '0;
        end else begin
            r_f_ctl <= i_ctl;
        end
        r_f_ex     <= EW'(i_px) - EW'(i_center_x);
        r_f_ey     <= EW'(i_py) - EW'(i_center_y);
        r_f_radius <= i_radius;
    end

    // ---- cell G: abs, extent tests, edge distance
    logic [EW-1:0]          w_ax, w_ay;
    logic [EW-1:0]          w_lim_x, w_lim_y;
    logic signed [NW-1:0]   w_nx, w_ny;
    t_ctl                   n_g_ctl;
    t_ctl                   r_g_ctl;
    logic                   r_g_both_pos;
    logic [EXT_WIDTH-1:0]   r_g_nx, r_g_ny, r_g_radius;

    always_comb begin
        w_ax    = r_f_ex[EW-1] ? EW'(-r_f_ex) : EW'(r_f_ex);
        w_ay    = r_f_ey[EW-1] ? EW'(-r_f_ey) : EW'(r_f_ey);
        w_lim_x = EW'(i_half_width) + EW'(r_f_radius);
        w_lim_y = EW'(i_half_height) + EW'(r_f_radius);
        w_nx    = signed'(NW'(w_ax)) - signed'(NW'(i_half_width));
        w_ny    = signed'(NW'(w_ay)) - signed'(NW'(i_half_height));
        n_g_ctl = r_f_ctl;
        if (!r_f_ctl.decided) begin
            if (w_ax > w_lim_x) begin
                n_g_ctl.decided = 1'b1;
                n_g_ctl.verdict = VERDICT_X_MISS;
            end else if (w_ay > w_lim_y) begin
                n_g_ctl.decided = 1'b1;
                n_g_ctl.verdict = VERDICT_Y_MISS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_ctl <= '0;
        end else begin
            r_g_ctl <= n_g_ctl;
        end
        // once both extents pass, a positive edge distance is at most the radius
        r_g_both_pos <= !w_nx[NW-1] && (w_nx != '0) && !w_ny[NW-1] && (w_ny != '0);
        r_g_nx       <= w_nx[EXT_WIDTH-1:0];
        r_g_ny       <= w_ny[EXT_WIDTH-1:0];
        r_g_radius   <= r_f_radius;
    end

    // ---- cell H: squares
    t_ctl          r_h_ctl;
    logic          r_h_both_pos;
    logic [QW-1:0] r_h_nx2, r_h_ny2, r_h_r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_ctl <= '0;
        end else begin
            r_h_ctl <= r_g_ctl;
        end
        r_h_both_pos <= r_g_both_pos;
        r_h_nx2      <= QW'(r_g_nx) * QW'(r_g_nx);
        r_h_ny2      <= QW'(r_g_ny) * QW'(r_g_ny);
        r_h_r2       <= QW'(r_g_radius) * QW'(r_g_radius);
    end

    // ---- cell I: corner distance, result register
    logic [QW:0] w_dist2;
    t_ctl        n_i_ctl;

    always_comb begin
        w_dist2 = (QW+1)'(r_h_nx2) + (QW+1)'(r_h_ny2);
        n_i_ctl = r_h_ctl;
        if (!r_h_ctl.decided) begin
            n_i_ctl.decided = 1'b1;
            n_i_ctl.verdict = (r_h_both_pos && (w_dist2 > (QW+1)'(r_h_r2)))
                            ? VERDICT_CORNER : VERDICT_HIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= n_i_ctl;
        end
    end

endmodule

`default_nettype wire

// ===== bench/oriented_rect_circle_collide_core_tb.sv =====
// Self-checking bench for oriented_rect_circle_collide_core: scoreboard class with
// its own contact predictor, directed boundary items, then random item streams.
// Depends on orcc_pkg and the core RTL.
`timescale 1ns / 1ps

module oriented_rect_circle_collide_core_tb;
    import orcc_pkg::*;

    localparam int CW           = COORD_WIDTH_DEF;
    localparam int CLK_HALF_NS  = 10;
    // settle time after the last result before touching registers
    localparam int SETTLE_CYCLES = 12;
    localparam int TIMEOUT_NS    = 4_000_000;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int NUM_PHASES      = 6;
    // share of random items with fully random fields
    localparam int NOISE_PCT       = 20;
    localparam longint COORD_MAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam longint TURN      = 65536;
    localparam longint QUARTER   = 16384;

    typedef struct packed {
        logic signed [CW-1:0]    rect_x;
        logic signed [CW-1:0]    rect_y;
        logic [ANGLE_WIDTH-1:0]  angle;
        logic signed [CW-1:0]    circle_x;
        logic signed [CW-1:0]    circle_y;
        logic [EXT_WIDTH-1:0]    circle_radius;
    } t_contact_item;

    // Predicts the verdict of each accepted item and holds them in order
    // until the matching result strobes out.
    class t_contact_scoreboard;
        localparam longint COARSE_SCALE = 2;
        localparam longint DEPTH        = SINE_TABLE_DEPTH_DEF;

        logic [EXT_WIDTH-1:0]  half_w;
        logic [EXT_WIDTH-1:0]  half_h;
        logic signed [CW-1:0]  off_x;
        logic signed [CW-1:0]  off_y;
        t_verdict              verdict_q[$];
        int unsigned           n_fail;
        int unsigned           n_checked;
        int unsigned           n_seen[5];

        function new();
            half_w = '0;
            half_h = '0;
            off_x  = '0;
            off_y  = '0;
            n_fail = 0;
            n_checked = 0;
            foreach (n_seen[k]) n_seen[k] = 0;
        endfunction

        function void set_reg(t_reg_index idx, logic [CW-1:0] data);
            case (idx)
                REG_HALF_WIDTH:  half_w = data[EXT_WIDTH-1:0];
                REG_HALF_HEIGHT: half_h = data[EXT_WIDTH-1:0];
                REG_CENTER_X:    off_x  = data;
                REG_CENTER_Y:    off_y  = data;
                default: ;
            endcase
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // floor((v + 2^14) / 2^15)
        function longint round_q15(longint v);
            return (v + 16384) >>> 15;
        endfunction

        // Q15 sine from the table, phase in 1/65536 turn
        function longint sine_at(longint phase);
            longint slot;
            longint t;
            longint quad;
            longint x;
            longint x2;
            longint p;
            slot = ((phase % TURN) * DEPTH) >> 16;
            t    = (slot * TURN) / DEPTH;
            quad = (t >> 14) & 3;
            x    = (t & (QUARTER - 1)) << 1;
            if (quad % 2 == 1) x = 32768 - x;
            x2 = (x * x) >> 15;
            p  = 21024 - ((2320 * x2) >> 15);
            p  = 51472 - ((p * x2) >> 15);
            p  = (p * x) >> 15;
            return (quad >= 2) ? -p : p;
        endfunction

        function t_verdict predict(t_contact_item it);
            longint hw;
            longint hh;
            longint r;
            longint dx;
            longint dy;
            longint b;
            longint s;
            longint c;
            longint ax;
            longint ay;
            longint nx;
            longint ny;
            hw = half_w;
            hh = half_h;
            r  = it.circle_radius;
            dx = longint'($signed(it.circle_x)) - longint'($signed(it.rect_x));
            dy = longint'($signed(it.circle_y)) - longint'($signed(it.rect_y));
            if (mag(dx) + mag(dy) >
                COARSE_SCALE * (hw + hh + r) + mag(off_x) + mag(off_y)) begin
                return VERDICT_COARSE;
            end
            b  = (longint'(it.angle) + QUARTER) % TURN;
            s  = sine_at(b);
            c  = sine_at(b + QUARTER);
            ax = mag(round_q15(dx * c - dy * s) - longint'(off_x));
            ay = mag(round_q15(dx * s + dy * c) - longint'(off_y));
            if (ax > hw + r) return VERDICT_X_MISS;
            if (ay > hh + r) return VERDICT_Y_MISS;
            nx = ax - hw;
            ny = ay - hh;
            if (nx > 0 && ny > 0 && nx * nx + ny * ny > r * r) return VERDICT_CORNER;
            return VERDICT_HIT;
        endfunction

        function void note_item(t_contact_item it);
            verdict_q.push_back(predict(it));
        endfunction

        function void check_result(logic hit, logic [2:0] verdict);
            t_verdict want;
            logic     want_hit;
            if (verdict_q.size() == 0) begin
                $error("result with no item outstanding: hit %0d verdict %0d", hit, verdict);
                n_fail++;
                return;
            end
            want     = verdict_q.pop_front();
            want_hit = (want == VERDICT_HIT);
            n_checked++;
            n_seen[int'(want)]++;
            if (hit !== want_hit) begin
                $error("hit: expected %0d, got %0d", want_hit, hit);
                n_fail++;
            end
            if (verdict !== want) begin
                $error("verdict: expected %0d (%s), got %0d", want, want.name(), verdict);
                n_fail++;
            end
        endfunction

        function int outstanding();
            return verdict_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block signals; every input holds a known value from time zero.
    // ------------------------------------------------------------------
    logic                       i_clk;
    logic                       i_rst_n         = 1'b0;
    logic                       start           = 1'b0;
    logic                       busy;
    logic signed [CW-1:0]       i_rect_x        = '0;
    logic signed [CW-1:0]       i_rect_y        = '0;
    logic [ANGLE_WIDTH-1:0]     i_angle         = '0;
    logic signed [CW-1:0]       i_circle_x      = '0;
    logic signed [CW-1:0]       i_circle_y      = '0;
    logic [EXT_WIDTH-1:0]       i_circle_radius = '0;
    logic                       o_strobe;
    logic                       o_hit;
    logic [2:0]                 o_verdict;
    logic                       i_cfg_we        = 1'b0;
    logic [1:0]                 i_cfg_index     = '0;
    logic [CW-1:0]              i_cfg_data      = '0;

    t_contact_scoreboard sb = new();
    int unsigned n_settings = 0;
    int unsigned n_items    = 0;

    oriented_rect_circle_collide_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_rect_x        (i_rect_x),
        .i_rect_y        (i_rect_y),
        .i_angle         (i_angle),
        .i_circle_x      (i_circle_x),
        .i_circle_y      (i_circle_y),
        .i_circle_radius (i_circle_radius),
        .o_strobe        (o_strobe),
        .o_hit           (o_hit),
        .o_verdict       (o_verdict),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // Results cannot be held off, so every strobe is checked at the edge that
    // closes its cycle. Values read here are the ones before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_result(o_hit, o_verdict);
        end
    end

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------

    // Writes all four registers on consecutive clocks. Upper data bits of the
    // 12-bit registers carry junk, which the block must drop.
    task automatic load_settings(input logic [EXT_WIDTH-1:0] hw, input logic [EXT_WIDTH-1:0] hh,
                                 input logic [CW-1:0] ox, input logic [CW-1:0] oy);
        logic [CW-1:0] vals[4];
        vals[0] = {(CW - EXT_WIDTH)'($urandom), hw};
        vals[1] = {(CW - EXT_WIDTH)'($urandom), hh};
        vals[2] = ox;
        vals[3] = oy;
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_reg_index'(k);
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            sb.set_reg(t_reg_index'(k), vals[k]);
        end
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Random gap cycles first (idle_pct is the per-cycle idle chance), then
    // hold start until the block takes the item.
    task automatic drive_item(input t_contact_item it, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_rect_x        <= it.rect_x;
        i_rect_y        <= it.rect_y;
        i_angle         <= it.angle;
        i_circle_x      <= it.circle_x;
        i_circle_y      <= it.circle_y;
        i_circle_radius <= it.circle_radius;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
        n_items++;
    endtask

    task automatic send(input longint rx, input longint ry, input longint ang,
                        input longint cx, input longint cy, input longint r);
        t_contact_item it;
        it.rect_x        = CW'(rx);
        it.rect_y        = CW'(ry);
        it.angle         = ANGLE_WIDTH'(ang);
        it.circle_x      = CW'(cx);
        it.circle_y      = CW'(cy);
        it.circle_radius = EXT_WIDTH'(r);
        drive_item(it, 0);
    endtask

    // Wait for every outstanding result, then let the pipe go quiet.
    task automatic drain();
        start <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed pairs: pick a circle centre in the rectangle's own
    // frame near its extended outline, rotate it back into world offsets and
    // place the anchor so both points fit the coordinate range. The rest is
    // noise with every field random.
    function automatic t_contact_item make_contact_item();
        t_contact_item it;
        longint r;
        longint ex;
        longint ey;
        longint lx;
        longint ly;
        longint b;
        longint s;
        longint c;
        longint dx;
        longint dy;
        longint lo;
        longint hi;
        if ($urandom_range(0, 99) < NOISE_PCT) begin
            it.rect_x        = CW'($urandom);
            it.rect_y        = CW'($urandom);
            it.angle         = ANGLE_WIDTH'($urandom);
            it.circle_x      = CW'($urandom);
            it.circle_y      = CW'($urandom);
            it.circle_radius = EXT_WIDTH'($urandom);
            return it;
        end
        it.angle         = ANGLE_WIDTH'($urandom);
        it.circle_radius = ($urandom_range(0, 3) == 0) ? EXT_WIDTH'($urandom)
                                                      : EXT_WIDTH'($urandom_range(0, 255));
        r  = it.circle_radius;
        ex = (longint'(sb.half_w) + r) * 5 / 4 + 2;
        ey = (longint'(sb.half_h) + r) * 5 / 4 + 2;
        lx = longint'(sb.off_x) + longint'($urandom_range(0, 2 * ex)) - ex;
        ly = longint'(sb.off_y) + longint'($urandom_range(0, 2 * ey)) - ey;
        b  = (longint'(it.angle) + QUARTER) % TURN;
        s  = sb.sine_at(b);
        c  = sb.sine_at(b + QUARTER);
        // inverse of the block's rotation
        dx = sb.round_q15(lx * c + ly * s);
        dy = sb.round_q15(ly * c - lx * s);
        lo = (dx < 0) ? COORD_MIN - dx : COORD_MIN;
        hi = (dx > 0) ? COORD_MAX - dx : COORD_MAX;
        it.rect_x   = CW'(lo + longint'($urandom_range(0, hi - lo)));
        it.circle_x = CW'(longint'(it.rect_x) + dx);
        lo = (dy < 0) ? COORD_MIN - dy : COORD_MIN;
        hi = (dy > 0) ? COORD_MAX - dy : COORD_MAX;
        it.rect_y   = CW'(lo + longint'($urandom_range(0, hi - lo)));
        it.circle_y = CW'(longint'(it.rect_y) + dy);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int idle_pct;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: box 100 x 40 half extents, centre offset (20, -10).
        // Angle 0xC000 makes the rotation exact identity, so the boundary
        // cases below land exactly on each comparison.
        load_settings(12'd100, 12'd40, CW'(20), CW'(-10));
        send(0, 0, 16'hC000, 370, 0, 30);      // Manhattan sum equals bound: passes, x miss
        send(0, 0, 16'hC000, 371, 0, 30);      // one past the bound: coarse reject
        send(0, 0, 16'hC000, 150, -10, 30);    // x extent equality: hit
        send(0, 0, 16'hC000, 151, -10, 30);    // x miss by one
        send(0, 0, 16'hC000, 20, 60, 30);      // y extent equality: hit
        send(0, 0, 16'hC000, 20, 61, 30);      // y miss by one
        send(0, 0, 16'hC000, 20, -80, 30);     // y equality, other side
        send(0, 0, 16'hC000, 138, 54, 30);     // corner distance equals radius: hit
        send(0, 0, 16'hC000, 138, 55, 30);     // corner miss
        send(0, 0, 16'hC000, -98, -65, 30);    // corner region, opposite corner, inside the radius: hit
        send(0, 0, 16'hC000, 20, -10, 0);      // dead centre, zero radius
        send(0, 0, 16'hC000, 120, 30, 0);      // exactly on the corner, zero radius
        send(-32768, -32768, 16'h0000, 32767, 32767, 4095);
        send(32767, 32767, 16'hFFFF, -32768, -32768, 0);
        send(-32768, 32767, 16'hC000, -32748, 32757, 30);
        send(1000, -1000, 16'h0000, 1010, -980, 4095);
        send(-5000, 5000, 16'h4000, -4990, 5020, 0);
        send(300, 300, 16'h8000, 280, 310, 12);
        send(0, 0, 16'h2000, 50, 50, 4095);
        send(0, 0, 16'hFFFF, 0, 0, 0);
        send(0, 0, 16'h6000, -140, 0, 20);
        drain();

        // Random phases: sender gaps 36 %, then 58 %, then none; each phase
        // runs under its own register setting, extremes included.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: load_settings(12'd200, 12'd80, CW'(16), CW'(-24));
                1: load_settings(12'd0, 12'd0, CW'(0), CW'(0));
                2: load_settings(12'd4095, 12'd4095, CW'(COORD_MAX), CW'(COORD_MIN));
                3: load_settings(EXT_WIDTH'($urandom_range(0, 600)),
                                 EXT_WIDTH'($urandom_range(0, 600)),
                                 CW'(int'($urandom_range(0, 2000)) - 1000),
                                 CW'(int'($urandom_range(0, 2000)) - 1000));
                4: load_settings(12'd4095, 12'd0, CW'(COORD_MIN), CW'(COORD_MAX));
                default: load_settings(EXT_WIDTH'($urandom), EXT_WIDTH'($urandom),
                                       CW'($urandom), CW'($urandom));
            endcase
            idle_pct = (p < 2) ? 36 : (p < 4) ? 58 : 0;
            repeat (ITEMS_PER_PHASE) drive_item(make_contact_item(), idle_pct);
            drain();
        end

        $display("Ran %0d items under %0d register settings, sender gaps of 36, 58 and 0 percent.",
                 n_items, n_settings);
        $display("Verdicts seen: coarse %0d, x miss %0d, y miss %0d, corner %0d, hit %0d.",
                 sb.n_seen[VERDICT_COARSE], sb.n_seen[VERDICT_X_MISS], sb.n_seen[VERDICT_Y_MISS],
                 sb.n_seen[VERDICT_CORNER], sb.n_seen[VERDICT_HIT]);
        if (sb.n_fail == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop, far beyond the slowest correct run.
    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d results outstanding.", sb.outstanding());
        $display("== FAIL ==");
        $finish;
    end

endmodule
